// File: rtl/sst_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helpers of the scoped symbol table
package sst_pkg;

    // default sizes
    localparam int NAME_COUNT_DEF  = 1024;
    localparam int DECL_BITS_DEF   = 16;
    localparam int UNDO_DEPTH_DEF  = 1024;
    localparam int SCOPE_DEPTH_DEF = 64;

    // width of the name id field on the port
    localparam int NAME_IN_BITS = 10;
    // reduction step counter, enough for any name count of two or more
    localparam int STEP_BITS = 4;

    // actions
    localparam logic [1:0] ACT_DECLARE = 2'd0;
    localparam logic [1:0] ACT_LOOKUP  = 2'd1;
    localparam logic [1:0] ACT_OPEN    = 2'd2;
    localparam logic [1:0] ACT_CLOSE   = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_REDECL      = 3'd1;
    localparam logic [2:0] ST_SCOPE_FULL  = 3'd2;
    localparam logic [2:0] ST_UNDO_FULL   = 3'd3;
    localparam logic [2:0] ST_CLOSE_OUTER = 3'd4;

    // shared unit operations
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [9:0]  name_id;
        logic [15:0] decl_handle;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [15:0] bound_decl;
        logic [2:0]  status;
    } t_out;

    typedef struct packed {
        logic ge;
    } t_alu_flags;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// File: rtl/sst_alu.sv
`timescale 1ns / 1ps
// shared add / subtract / compare unit used by the sequencer
module sst_alu #(
    parameter int W = 17
) (
    input  logic                  i_op,
    input  logic [W-1:0]          i_a,
    input  logic [W-1:0]          i_b,
    output logic [W-1:0]          o_res,
    output sst_pkg::t_alu_flags   o_flags
);

    logic [W-1:0] b_eff;
    logic [W:0]   sum;

    // one adder: subtract is a plus inverted b plus one
    assign b_eff = (i_op == sst_pkg::ALU_SUB) ? ~i_b : i_b;
    assign sum   = {1'b0, i_a} + {1'b0, b_eff} + {{W{1'b0}}, (i_op == sst_pkg::ALU_SUB)};

    assign o_res      = sum[W-1:0];
    // carry out of a subtract means a >= b
    assign o_flags.ge = sum[W];

endmodule

// File: rtl/sst_outbuf.sv
`timescale 1ns / 1ps
// output register holding one result beat until the consumer takes it
module sst_outbuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load_valid,
    input  sst_pkg::t_out i_load_data,
    output logic          o_load_taken,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sst_pkg::t_out o_out_data
);

    logic          r_valid;
    sst_pkg::t_out r_data;

    // free when empty or draining this cycle
    assign o_load_taken = i_load_valid && (!r_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_taken) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_taken) begin
            r_data <= i_load_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// File: rtl/scoped_symbol_table_top.sv
`timescale 1ns / 1ps
// scoped symbol table: sequencer, binding / undo / scope memories, shared unit
//
//  channel | dir | handshake                   | beat
//  --------+-----+-----------------------------+-----------------------------
//  input   | in  | i_in_valid / o_in_ready     | i_in_data  (action, name, handle)
//  output  | out | o_out_valid / i_out_ready   | o_out_data (found, handle, status)
//
//  one item at a time; reduction, checks and counter steps use the one shared add/compare
//  unit. lookup: name reduction (none when the name count covers all 1024 ids), binding
//  read, result; declare adds a check and, when it binds, a log push; open is a check
//  and, with room, a level push; close restores the scope's undo entries newest first,
//  then leaves the scope (not at the outermost). after reset the binding store is swept
//  clear with o_in_ready low. a stalled output holds the finished item in its register;
//  the next item is taken meanwhile and waits at its own end for the slot.
module scoped_symbol_table_top #(
    parameter int NAME_COUNT  = sst_pkg::NAME_COUNT_DEF,
    parameter int DECL_BITS   = sst_pkg::DECL_BITS_DEF,
    parameter int UNDO_DEPTH  = sst_pkg::UNDO_DEPTH_DEF,
    parameter int SCOPE_DEPTH = sst_pkg::SCOPE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sst_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sst_pkg::t_out o_out_data
);

    localparam int NAME_BITS     = $clog2(NAME_COUNT);
    localparam int LEVEL_BITS    = $clog2(SCOPE_DEPTH);
    localparam int UNDO_IDX_BITS = $clog2(UNDO_DEPTH);
    localparam int UNDO_PTR_BITS = $clog2(UNDO_DEPTH + 1);
    localparam int BIND_W        = 1 + LEVEL_BITS + DECL_BITS;
    localparam int UNDO_W        = NAME_BITS + BIND_W;
    localparam int ALU_W = sst_pkg::max_int(sst_pkg::max_int(UNDO_PTR_BITS, LEVEL_BITS),
                           sst_pkg::max_int(NAME_BITS, sst_pkg::NAME_IN_BITS + 1));
    localparam int NAME_SPAN = 1 << sst_pkg::NAME_IN_BITS;
    // restoring reduction of the port id modulo the name count
    localparam int RED_STEPS = (NAME_COUNT >= NAME_SPAN) ? 0 :
                               $clog2((NAME_SPAN + NAME_COUNT - 1) / NAME_COUNT);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_REDUCE    = 4'd2;
    localparam logic [3:0] S_RD_BIND   = 4'd3;
    localparam logic [3:0] S_DECL_CHK  = 4'd4;
    localparam logic [3:0] S_DECL_INC  = 4'd5;
    localparam logic [3:0] S_LOOK      = 4'd6;
    localparam logic [3:0] S_OPEN_CHK  = 4'd7;
    localparam logic [3:0] S_OPEN_INC  = 4'd8;
    localparam logic [3:0] S_CLOSE_CHK = 4'd9;
    localparam logic [3:0] S_WALK_CHK  = 4'd10;
    localparam logic [3:0] S_WALK_DEC  = 4'd11;
    localparam logic [3:0] S_WALK_WR   = 4'd12;
    localparam logic [3:0] S_CLOSE_DEC = 4'd13;
    localparam logic [3:0] S_RESP      = 4'd14;

    // control registers
    logic [3:0]                   r_state, n_state;
    logic [UNDO_PTR_BITS-1:0]     r_undo_top, n_undo_top;
    logic [LEVEL_BITS-1:0]        r_level, n_level;
    logic [NAME_BITS-1:0]         r_clr, n_clr;
    logic [sst_pkg::STEP_BITS-1:0] r_step, n_step;

    // item registers
    logic [1:0]                   r_action;
    logic [DECL_BITS-1:0]         r_decl;
    logic [sst_pkg::NAME_IN_BITS-1:0] r_name, n_name;
    sst_pkg::t_out                r_res, n_res;

    // memories
    logic [BIND_W-1:0]            bind_mem [NAME_COUNT];
    logic [UNDO_W-1:0]            undo_mem [UNDO_DEPTH];
    logic [UNDO_PTR_BITS-1:0]     scope_mem [SCOPE_DEPTH];
    logic [BIND_W-1:0]            r_bind_rd;
    logic [UNDO_W-1:0]            r_undo_rd;
    logic [UNDO_PTR_BITS-1:0]     r_scope_rd;

    logic                         bind_we, bind_re;
    logic [NAME_BITS-1:0]         bind_addr;
    logic [BIND_W-1:0]            bind_wdata;
    logic                         undo_we, undo_re;
    logic [UNDO_IDX_BITS-1:0]     undo_addr;
    logic [UNDO_W-1:0]            undo_wdata;
    logic                         scope_we, scope_re;
    logic [LEVEL_BITS-1:0]        scope_addr;

    // shared unit
    logic                         alu_op;
    logic [ALU_W-1:0]             alu_a, alu_b, alu_res;
    sst_pkg::t_alu_flags          alu_flags;

    logic                         in_accept;
    logic                         res_taken;
    logic [NAME_BITS-1:0]         name_idx;
    logic                         bind_valid;
    logic [LEVEL_BITS-1:0]        bind_level;
    logic [DECL_BITS-1:0]         bind_decl;

    sst_alu #(.W(ALU_W)) u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_flags (alu_flags)
    );

    sst_outbuf u_outbuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_state == S_RESP),
        .i_load_data  (r_res),
        .o_load_taken (res_taken),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign name_idx   = NAME_BITS'(r_name);
    assign bind_valid = r_bind_rd[BIND_W-1];
    assign bind_level = r_bind_rd[DECL_BITS +: LEVEL_BITS];
    assign bind_decl  = r_bind_rd[DECL_BITS-1:0];

    always_comb begin
        n_state    = r_state;
        n_undo_top = r_undo_top;
        n_level    = r_level;
        n_clr      = r_clr;
        n_step     = r_step;
        n_name     = r_name;
        n_res      = r_res;
        bind_we    = 1'b0;
        bind_re    = 1'b0;
        bind_addr  = name_idx;
        bind_wdata = {1'b1, r_level, r_decl};
        undo_we    = 1'b0;
        undo_re    = 1'b0;
        undo_addr  = r_undo_top[UNDO_IDX_BITS-1:0];
        undo_wdata = {name_idx, r_bind_rd};
        scope_we   = 1'b0;
        scope_re   = 1'b0;
        scope_addr = r_level;
        alu_op     = sst_pkg::ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;

        unique case (r_state)
            S_CLEAR: begin
                bind_we    = 1'b1;
                bind_addr  = r_clr;
                bind_wdata = '0;
                alu_a      = ALU_W'(r_clr);
                alu_b      = ALU_W'(1);
                n_clr      = NAME_BITS'(alu_res);
                if (r_clr == NAME_BITS'(NAME_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_name = i_in_data.name_id;
                    n_step = sst_pkg::STEP_BITS'(sst_pkg::max_int(RED_STEPS - 1, 0));
                    n_res  = '{found: 1'b0, bound_decl: '0, status: sst_pkg::ST_OK};
                    unique case (i_in_data.action)
                        sst_pkg::ACT_DECLARE,
                        sst_pkg::ACT_LOOKUP: n_state = (RED_STEPS > 0) ? S_REDUCE : S_RD_BIND;
                        sst_pkg::ACT_OPEN:   n_state = S_OPEN_CHK;
                        default:             n_state = S_CLOSE_CHK;
                    endcase
                end
            end
            S_REDUCE: begin
                alu_op = sst_pkg::ALU_SUB;
                alu_a  = ALU_W'(r_name);
                alu_b  = ALU_W'(NAME_COUNT) << r_step;
                if (alu_flags.ge) begin
                    n_name = sst_pkg::NAME_IN_BITS'(alu_res);
                end
                if (r_step == '0) begin
                    n_state = S_RD_BIND;
                end else begin
                    n_step = r_step - sst_pkg::STEP_BITS'(1);
                end
            end
            S_RD_BIND: begin
                bind_re = 1'b1;
                n_state = (r_action == sst_pkg::ACT_DECLARE) ? S_DECL_CHK : S_LOOK;
            end
            S_DECL_CHK: begin
                alu_op = sst_pkg::ALU_SUB;
                alu_a  = ALU_W'(r_undo_top);
                alu_b  = ALU_W'(UNDO_DEPTH);
                if (bind_valid && (bind_level == r_level)) begin
                    n_res.status = sst_pkg::ST_REDECL;
                    n_state      = S_RESP;
                end else if (alu_flags.ge) begin
                    n_res.status = sst_pkg::ST_UNDO_FULL;
                    n_state      = S_RESP;
                end else begin
                    // log the shadowed binding, then bind in this scope
                    undo_we = 1'b1;
                    bind_we = 1'b1;
                    n_state = S_DECL_INC;
                end
            end
            S_DECL_INC: begin
                alu_a      = ALU_W'(r_undo_top);
                alu_b      = ALU_W'(1);
                n_undo_top = UNDO_PTR_BITS'(alu_res);
                n_state    = S_RESP;
            end
            S_LOOK: begin
                n_res.found      = bind_valid;
                n_res.bound_decl = bind_valid ? 16'(bind_decl) : 16'd0;
                n_state          = S_RESP;
            end
            S_OPEN_CHK: begin
                alu_op = sst_pkg::ALU_SUB;
                alu_a  = ALU_W'(r_level);
                alu_b  = ALU_W'(SCOPE_DEPTH - 1);
                if (alu_flags.ge) begin
                    n_res.status = sst_pkg::ST_SCOPE_FULL;
                    n_state      = S_RESP;
                end else begin
                    n_state = S_OPEN_INC;
                end
            end
            S_OPEN_INC: begin
                alu_a      = ALU_W'(r_level);
                alu_b      = ALU_W'(1);
                n_level    = LEVEL_BITS'(alu_res);
                scope_we   = 1'b1;
                scope_addr = LEVEL_BITS'(alu_res);
                n_state    = S_RESP;
            end
            S_CLOSE_CHK: begin
                if (r_level == '0) begin
                    n_res.status = sst_pkg::ST_CLOSE_OUTER;
                    n_state      = S_RESP;
                end else begin
                    scope_re = 1'b1;
                    n_state  = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                // done once the log is back at this scope's base
                alu_op = sst_pkg::ALU_SUB;
                alu_a  = ALU_W'(r_scope_rd);
                alu_b  = ALU_W'(r_undo_top);
                n_state = alu_flags.ge ? S_CLOSE_DEC : S_WALK_DEC;
            end
            S_WALK_DEC: begin
                alu_op     = sst_pkg::ALU_SUB;
                alu_a      = ALU_W'(r_undo_top);
                alu_b      = ALU_W'(1);
                n_undo_top = UNDO_PTR_BITS'(alu_res);
                undo_re    = 1'b1;
                undo_addr  = UNDO_IDX_BITS'(alu_res);
                n_state    = S_WALK_WR;
            end
            S_WALK_WR: begin
                bind_we    = 1'b1;
                bind_addr  = r_undo_rd[UNDO_W-1 -: NAME_BITS];
                bind_wdata = r_undo_rd[BIND_W-1:0];
                n_state    = S_WALK_CHK;
            end
            S_CLOSE_DEC: begin
                alu_op  = sst_pkg::ALU_SUB;
                alu_a   = ALU_W'(r_level);
                alu_b   = ALU_W'(1);
                n_level = LEVEL_BITS'(alu_res);
                n_state = S_RESP;
            end
            S_RESP: begin
                if (res_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_undo_top <= '0;
            r_level    <= '0;
            r_clr      <= '0;
            r_step     <= '0;
        end else begin
            r_state    <= n_state;
            r_undo_top <= n_undo_top;
            r_level    <= n_level;
            r_clr      <= n_clr;
            r_step     <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_name <= n_name;
        r_res  <= n_res;
        if (in_accept) begin
            r_action <= i_in_data.action;
            r_decl   <= DECL_BITS'(i_in_data.decl_handle);
        end
    end

    always_ff @(posedge i_clk) begin
        if (bind_we) begin
            bind_mem[bind_addr] <= bind_wdata;
        end
        if (bind_re) begin
            r_bind_rd <= bind_mem[bind_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (undo_we) begin
            undo_mem[undo_addr] <= undo_wdata;
        end
        if (undo_re) begin
            r_undo_rd <= undo_mem[undo_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (scope_we) begin
            scope_mem[scope_addr] <= r_undo_top;
        end
        if (scope_re) begin
            r_scope_rd <= scope_mem[scope_addr];
        end
    end

`ifndef ASSERT_OFF
    a_undo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_undo_top <= UNDO_PTR_BITS'(UNDO_DEPTH))
        else $error("undo log pointer past its depth");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LEVEL_BITS'(SCOPE_DEPTH - 1))
        else $error("scope level past its depth");

    a_walk_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLOSE_DEC) |-> (r_undo_top == r_scope_rd))
        else $error("scope closed with log not at its base");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("second beat taken while an item is in work");

    a_close_drops_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLOSE_DEC) |=> (r_level == $past(r_level) - LEVEL_BITS'(1)))
        else $error("close did not leave the scope");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// testbench of the scoped symbol table: directed rows, a nesting run, random scopes
module tb_top;

    localparam int NAMES        = sst_pkg::NAME_COUNT_DEF;
    localparam int LOG_DEPTH    = sst_pkg::UNDO_DEPTH_DEF;
    localparam int NEST_DEPTH   = sst_pkg::SCOPE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 380;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [9:0]  name;
        bit          live;
        logic [15:0] handle;
        int unsigned level;
    } t_shadow;

    typedef struct {
        sst_pkg::t_in  beat;
        bit            typed;
        sst_pkg::t_out want;
    } t_row;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    sst_pkg::t_in  in_data   = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    sst_pkg::t_out out_data;

    int send_idle     = 0;
    int recv_stall    = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int errors        = 0;

    // binding table mirror
    bit          sym_live   [NAMES];
    logic [15:0] sym_handle [NAMES];
    int unsigned sym_level  [NAMES];
    t_shadow     shadow_log [LOG_DEPTH];
    int unsigned shadow_top = 0;
    int unsigned scope_mark [NEST_DEPTH];
    int unsigned cur_scope  = 0;

    sst_pkg::t_out pending_replies [$];
    t_row          dir_rows [$];

    scoped_symbol_table_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic sst_pkg::t_out resolve_symbol(input sst_pkg::t_in beat);
        sst_pkg::t_out res;
        logic [9:0]    n;
        res = '0;
        n   = beat.name_id;
        case (beat.action)
            sst_pkg::ACT_DECLARE: begin
                if (sym_live[n] && sym_level[n] == cur_scope) begin
                    res.status = sst_pkg::ST_REDECL;
                end else if (shadow_top >= LOG_DEPTH) begin
                    res.status = sst_pkg::ST_UNDO_FULL;
                end else begin
                    shadow_log[shadow_top].name   = n;
                    shadow_log[shadow_top].live   = sym_live[n];
                    shadow_log[shadow_top].handle = sym_handle[n];
                    shadow_log[shadow_top].level  = sym_level[n];
                    shadow_top++;
                    sym_live[n]   = 1'b1;
                    sym_handle[n] = beat.decl_handle;
                    sym_level[n]  = cur_scope;
                end
            end
            sst_pkg::ACT_LOOKUP: begin
                if (sym_live[n]) begin
                    res.found      = 1'b1;
                    res.bound_decl = sym_handle[n];
                end
            end
            sst_pkg::ACT_OPEN: begin
                if (cur_scope + 1 >= NEST_DEPTH) begin
                    res.status = sst_pkg::ST_SCOPE_FULL;
                end else begin
                    cur_scope++;
                    scope_mark[cur_scope] = shadow_top;
                end
            end
            default: begin
                if (cur_scope == 0) begin
                    res.status = sst_pkg::ST_CLOSE_OUTER;
                end else begin
                    // unwind newest first
                    while (shadow_top > scope_mark[cur_scope]) begin
                        shadow_top--;
                        n             = shadow_log[shadow_top].name;
                        sym_live[n]   = shadow_log[shadow_top].live;
                        sym_handle[n] = shadow_log[shadow_top].handle;
                        sym_level[n]  = shadow_log[shadow_top].level;
                    end
                    cur_scope--;
                end
            end
        endcase
        return res;
    endfunction

    function automatic sst_pkg::t_in make_beat(input logic [1:0] act, input int unsigned name,
                                               input int unsigned handle);
        sst_pkg::t_in b;
        b.action      = act;
        b.name_id     = name[9:0];
        b.decl_handle = handle[15:0];
        return b;
    endfunction

    function automatic sst_pkg::t_in random_beat();
        sst_pkg::t_in b;
        int unsigned  pick;
        int unsigned  sel;
        pick = $urandom_range(99);
        if (pick < 38) begin
            b.action = sst_pkg::ACT_DECLARE;
        end else if (pick < 70) begin
            b.action = sst_pkg::ACT_LOOKUP;
        end else if (pick < 85) begin
            b.action = sst_pkg::ACT_OPEN;
        end else begin
            // close inside a scope; at the outermost level mostly reopen, sometimes a stray close
            b.action = (cur_scope == 0 && pick < 97) ? sst_pkg::ACT_OPEN : sst_pkg::ACT_CLOSE;
        end
        sel = $urandom_range(9);
        if (sel < 5)
            b.name_id = 10'($urandom_range(15));
        else if (sel == 5)
            b.name_id = $urandom_range(1) ? 10'd1023 : 10'd0;
        else
            b.name_id = 10'($urandom_range(1023));
        sel = $urandom_range(9);
        if (sel == 0)
            b.decl_handle = $urandom_range(1) ? 16'hffff : 16'h0000;
        else
            b.decl_handle = 16'($urandom_range(65535));
        return b;
    endfunction

    task automatic add_row(input logic [1:0] act, input int unsigned name,
                           input int unsigned handle, input bit typed, input bit found,
                           input int unsigned decl, input logic [2:0] status);
        t_row r;
        r.beat            = make_beat(act, name, handle);
        r.typed           = typed;
        r.want.found      = found;
        r.want.bound_decl = decl[15:0];
        r.want.status     = status;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // present one beat, wait for the handshake, then record what should come back
    task automatic offer(input sst_pkg::t_in beat, input bit typed, input sst_pkg::t_out want);
        sst_pkg::t_out guess;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        guess = resolve_symbol(beat);
        pending_replies.insert(pending_replies.size(), typed ? want : guess);
    endtask

    always @(posedge clk) begin : drive_ready
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk) begin : check_replies
        sst_pkg::t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_replies.size() == 0) begin
                $error("reply beat with nothing pending: %p", out_data);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (out_data.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, out_data.found);
                    errors++;
                end
                if (out_data.bound_decl !== want.bound_decl) begin
                    $error("bound_decl: expected %h, got %h", want.bound_decl,
                           out_data.bound_decl);
                    errors++;
                end
                if (out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        //      action                name  handle    typed found decl      status
        add_row(sst_pkg::ACT_LOOKUP,  0,    16'h0000, 1,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_LOOKUP,  1023, 16'hffff, 1,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_CLOSE,   0,    16'h0000, 1,    0,    16'h0000,
                sst_pkg::ST_CLOSE_OUTER);
        add_row(sst_pkg::ACT_DECLARE, 1023, 16'hffff, 1,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_DECLARE, 1023, 16'h1234, 1,    0,    16'h0000, sst_pkg::ST_REDECL);
        add_row(sst_pkg::ACT_LOOKUP,  1023, 16'h0000, 1,    1,    16'hffff, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_DECLARE, 0,    16'h0000, 1,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_LOOKUP,  0,    16'hffff, 1,    1,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_OPEN,    1023, 16'hffff, 1,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_DECLARE, 1023, 16'h0000, 1,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_LOOKUP,  1023, 16'h0000, 1,    1,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_DECLARE, 1023, 16'haaaa, 1,    0,    16'h0000, sst_pkg::ST_REDECL);
        add_row(sst_pkg::ACT_DECLARE, 512,  16'h5555, 0,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_OPEN,    0,    16'h0000, 0,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_DECLARE, 0,    16'h8001, 0,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_LOOKUP,  0,    16'h0000, 1,    1,    16'h8001, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_LOOKUP,  512,  16'h0000, 0,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_CLOSE,   0,    16'h0000, 0,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_LOOKUP,  0,    16'h0000, 0,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_CLOSE,   0,    16'h0000, 0,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_LOOKUP,  1023, 16'hffff, 0,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_LOOKUP,  512,  16'h0000, 0,    0,    16'h0000, sst_pkg::ST_OK);
        add_row(sst_pkg::ACT_CLOSE,   511,  16'h7fff, 0,    0,    16'h0000, sst_pkg::ST_OK);

        foreach (dir_rows[i])
            offer(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

        // nest to the deepest scope, overflow it, then unwind past the outermost
        send_idle  = 28;
        recv_stall = 28;
        while (cur_scope < NEST_DEPTH - 1) begin
            offer(make_beat(sst_pkg::ACT_OPEN, 0, 0), 1'b0, '0);
            if ($urandom_range(3) == 0)
                offer(make_beat(sst_pkg::ACT_DECLARE, $urandom_range(15), $urandom), 1'b0, '0);
        end
        offer(make_beat(sst_pkg::ACT_OPEN, 0, 0), 1'b0, '0);
        offer(make_beat(sst_pkg::ACT_LOOKUP, $urandom_range(15), 0), 1'b0, '0);
        while (cur_scope > 0)
            offer(make_beat(sst_pkg::ACT_CLOSE, 0, 0), 1'b0, '0);
        offer(make_beat(sst_pkg::ACT_CLOSE, 0, 0), 1'b0, '0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case (i * 5 / RANDOM_ITEMS)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 47; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 47; end
                3: begin send_idle = 28; recv_stall = 28; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            // long output hold-off while beats keep coming
            if (i == RANDOM_ITEMS * 4 / 5)
                hold_requests++;
            offer(random_beat(), 1'b0, '0);
        end

        in_valid   <= 1'b0;
        recv_stall = 0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
